[rtl/stereo_linear_resampler_defines.svh]
// Assertion macros shared by the resampler control and datapath modules.
// Each user module must provide i_clk and the active-low reset i_rst_n.
`ifndef STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/slr_pkg.sv]
// Shared widths, codes and control structures of the stereo linear resampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package slr_pkg;

    localparam int RAW_W    = 32;
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 16;
    localparam int STEP_W   = 20;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_OUTPUTS_DEF = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // Register indexes, taken from paddr word address.
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_MONO_INPUT    = 2'd1;
    localparam logic [1:0] REG_STEP_RATIO    = 2'd2;

    typedef enum logic [1:0] {
        FMT_INT16   = 2'd0,
        FMT_INT32   = 2'd1,
        FMT_FLOAT32 = 2'd2,
        FMT_NONE    = 2'd3
    } t_fmt;

    typedef struct packed {
        t_fmt              fmt;
        logic              mono;
        logic [STEP_W-1:0] step;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic norm;
        logic mul;
        logic scale;
        logic load_out;
        logic last;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic phase_lt_one;
        logic next_lt_one;
    } t_status;

endpackage

[rtl/slr_in_if.sv]
// Input frame channel: valid/ready handshake carrying raw stereo samples.
// Depends on slr_pkg for the sample word width.
interface slr_in_if;
    import slr_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] left_raw;
    logic [RAW_W-1:0] right_raw;
    logic             silent;

    modport source (output valid, left_raw, right_raw, silent, input ready);
    modport sink   (input valid, left_raw, right_raw, silent, output ready);
endinterface

[rtl/slr_out_if.sv]
// Output sample channel: valid/ready handshake carrying signed 16-bit stereo samples.
// Depends on slr_pkg for the output width.
interface slr_out_if;
    import slr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    last;

    modport source (output valid, left_out, right_out, last, input ready);
    modport sink   (input valid, left_out, right_out, last, output ready);
endinterface

[rtl/stereo_linear_resampler.sv]
// Top level of the stereo linear resampler: APB register file, channel wiring,
// controller and datapath. Depends on slr_pkg, slr_in_if, slr_out_if, slr_ctrl, slr_datapath.
//
//   Channel   Direction  Handshake          Payload
//   i_in_ch   in         valid/ready        left_raw[32], right_raw[32], silent
//   o_out_ch  out        valid/ready        left_out[16] s, right_out[16] s, last
//   APB       in/out     psel/penable       sample_format, mono_input, step_ratio
//
// A frame is handled in steps: accept, normalise, then for each output multiply, scale and
// load the output register, and finally update the phase; a frame gives at most MAX_OUTPUTS
// outputs. Each output uses two multipliers per channel: the interpolation product, then the
// scaling by 32767.
// Reset is synchronous; the output register lets a result wait while the next frame is
// accepted, and a full output register holds the frame in progress until its transfer.
module stereo_linear_resampler #(
    parameter int FRAC_BITS   = slr_pkg::FRAC_BITS_DEF,
    parameter int MAX_OUTPUTS = slr_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    slr_in_if.sink                       i_in_ch,
    slr_out_if.source                    o_out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slr_pkg::ADDR_W-1:0]   paddr,
    input  logic [slr_pkg::DATA_W-1:0]   pwdata,
    output logic [slr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import slr_pkg::*;

    t_fmt              r_sample_format;
    logic              r_mono_input;
    logic [STEP_W-1:0] r_step_ratio;
    logic [1:0]        reg_idx;
    logic              cfg_wr;
    t_cfg              cfg;
    t_cmd              cmd;
    t_status           status;
    logic              in_ready;
    logic              out_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= FMT_INT16;
            r_mono_input    <= 1'b0;
            r_step_ratio    <= STEP_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLE_FORMAT: r_sample_format <= t_fmt'(pwdata[1:0]);
                REG_MONO_INPUT:    r_mono_input    <= pwdata[0];
                REG_STEP_RATIO:    r_step_ratio    <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SAMPLE_FORMAT: prdata = {{(DATA_W-2){1'b0}}, r_sample_format};
            REG_MONO_INPUT:    prdata = {{(DATA_W-1){1'b0}}, r_mono_input};
            REG_STEP_RATIO:    prdata = {{(DATA_W-STEP_W){1'b0}}, r_step_ratio};
            default:           prdata = '0;
        endcase
    end

    assign cfg.fmt  = r_sample_format;
    assign cfg.mono = r_mono_input;
    assign cfg.step = r_step_ratio;

    slr_ctrl #(
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    slr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_left_raw  (i_in_ch.left_raw),
        .i_right_raw (i_in_ch.right_raw),
        .i_silent    (i_in_ch.silent),
        .o_left_out  (o_out_ch.left_out),
        .o_right_out (o_out_ch.right_out),
        .o_last      (o_out_ch.last)
    );

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = out_valid;

endmodule

[rtl/slr_ctrl.sv]
// Sequencer of the resampler: accepts frames, steps the datapath per output.
// Depends on slr_pkg and stereo_linear_resampler_defines.svh.
`include "stereo_linear_resampler_defines.svh"

module slr_ctrl #(
    parameter int MAX_OUTPUTS = slr_pkg::MAX_OUTPUTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  slr_pkg::t_status i_status,
    output slr_pkg::t_cmd    o_cmd
);
    import slr_pkg::*;

    localparam int CNT_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUTPUTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_MUL,
        S_SCALE,
        S_OUT,
        S_END
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        out_free    = !r_out_valid || i_out_ready;
        o_cmd       = '0;
        o_cmd.last  = r_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_cnt      = '0;
                n_state    = i_status.phase_lt_one ? S_MUL : S_END;
            end
            S_MUL: begin
                // The output being started is the final one if the phase leaves
                // [0, 1) after this step or the per-frame cap is reached.
                o_cmd.mul = 1'b1;
                n_last    = !i_status.next_lt_one || (r_cnt == CNT_MAX);
                n_cnt     = CNT_W'(r_cnt + 1'b1);
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = r_last ? S_END : S_MUL;
                end
            end
            S_END: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SLR_ASSERT_NEXT(a_accept_to_norm, i_in_valid && o_in_ready, r_state == S_NORM, "accepted frame did not start normalisation")
    `SLR_ASSERT_NOW(a_mul_below_one, r_state == S_MUL, i_status.phase_lt_one, "output started with phase at or above one")
    `SLR_ASSERT_NEXT(a_last_ends_frame, o_cmd.load_out && o_cmd.last, r_state == S_END, "final output did not close the frame")

endmodule

[rtl/slr_datapath.sv]
// Datapath of the resampler: sample normalisation, phase accumulator, interpolation multiply,
// output scaling and the output register. Depends on slr_pkg and stereo_linear_resampler_defines.svh.
`include "stereo_linear_resampler_defines.svh"

module slr_datapath #(
    parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slr_pkg::t_cfg                       i_cfg,
    input  slr_pkg::t_cmd                       i_cmd,
    output slr_pkg::t_status                    o_status,
    input  logic [slr_pkg::RAW_W-1:0]           i_left_raw,
    input  logic [slr_pkg::RAW_W-1:0]           i_right_raw,
    input  logic                                i_silent,
    output logic signed [slr_pkg::OUT_W-1:0]    o_left_out,
    output logic signed [slr_pkg::OUT_W-1:0]    o_right_out,
    output logic                                o_last
);
    import slr_pkg::*;

    // The accumulator must hold a phase just below one plus the largest step.
    localparam int PH_W   = (FRAC_BITS + 4 > STEP_W + 1) ? FRAC_BITS + 4 : STEP_W + 1;
    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int SCL_W  = SAMPLE_W + OUT_W;

    localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0] PHASE_MAX = (PH_W'(1) << (FRAC_BITS + 4)) - PH_W'(1);

    localparam logic signed [OUT_W-1:0]    SCALE_K    = OUT_W'(32767);
    localparam logic signed [SCL_W-1:0]    TRUNC_BIAS = SCL_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SCL_W-1:0]    CLAMP_HI   = SCL_W'(32767);
    localparam logic signed [SCL_W-1:0]    CLAMP_LO   = -SCL_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] Q_POS_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] Q_NEG_MAX  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [7:0] EXP_BIAS = 8'd127;
    localparam logic [7:0] EXP_MIN  = 8'd104;
    localparam logic [7:0] EXP_SPEC = 8'hFF;

    // Float32 to Q1.23, truncating toward zero and saturating at magnitude one.
    function automatic logic signed [SAMPLE_W-1:0] f32_to_q(input logic [RAW_W-1:0] bits);
        logic [7:0]          ex;
        logic [22:0]         man;
        logic [7:0]          sh;
        logic [SAMPLE_W-1:0] mag;
        logic signed [SAMPLE_W-1:0] res;
        ex  = bits[30:23];
        man = bits[22:0];
        sh  = EXP_BIAS - ex;
        mag = {1'b1, man} >> sh[4:0];
        priority if (ex == EXP_SPEC && man != '0) begin
            res = '0;
        end else if (ex >= EXP_BIAS) begin
            res = bits[31] ? Q_NEG_MAX : Q_POS_MAX;
        end else if (ex < EXP_MIN) begin
            res = '0;
        end else begin
            res = bits[31] ? -mag : mag;
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_q(input t_fmt fmt,
                                                        input logic [RAW_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] res;
        unique case (fmt)
            FMT_INT16:   res = {raw[15:0], 8'h00};
            FMT_INT32:   res = raw[RAW_W-1:RAW_W-SAMPLE_W];
            FMT_FLOAT32: res = f32_to_q(raw);
            FMT_NONE:    res = '0;
        endcase
        return res;
    endfunction

    // Truncate the scaled product toward zero and clamp to 16 bits.
    function automatic logic signed [OUT_W-1:0] to_s16(input logic signed [SCL_W-1:0] p);
        logic signed [SCL_W-1:0] biased;
        logic signed [SCL_W-1:0] q;
        logic signed [OUT_W-1:0] res;
        biased = p + (p[SCL_W-1] ? TRUNC_BIAS : '0);
        q      = biased >>> (SAMPLE_W - 1);
        priority if (q > CLAMP_HI) begin
            res = CLAMP_HI[OUT_W-1:0];
        end else if (q < CLAMP_LO) begin
            res = CLAMP_LO[OUT_W-1:0];
        end else begin
            res = q[OUT_W-1:0];
        end
        return res;
    endfunction

    logic [RAW_W-1:0]           r_left_raw, r_right_raw;
    logic                       r_silent;
    logic signed [SAMPLE_W-1:0] r_cur_l, r_cur_r;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r;
    logic                       r_primed;
    logic [PH_W-1:0]            r_phase;
    logic signed [PROD_W-1:0]   r_prod_l, r_prod_r;
    logic signed [SCL_W-1:0]    r_scl_l, r_scl_r;
    logic signed [OUT_W-1:0]    r_left_out, r_right_out;
    logic                       r_last;

    logic signed [SAMPLE_W-1:0] n_norm_l, n_norm_r;
    logic [PH_W-1:0]            n_phase_sum, n_phase_drop;
    logic signed [SAMPLE_W:0]   diff_l, diff_r;
    logic signed [FRAC_BITS:0]  frac;
    logic signed [PROD_W-1:0]   shift_l, shift_r;
    logic signed [SAMPLE_W-1:0] interp_l, interp_r;

    always_comb begin
        n_norm_l = '0;
        n_norm_r = '0;
        if (!r_silent) begin
            n_norm_l = to_q(i_cfg.fmt, r_left_raw);
            n_norm_r = i_cfg.mono ? n_norm_l : to_q(i_cfg.fmt, r_right_raw);
        end
    end

    always_comb begin
        n_phase_sum  = r_phase + PH_W'(i_cfg.step);
        n_phase_drop = '0;
        if (r_phase >= PHASE_ONE) begin
            n_phase_drop = r_phase - PHASE_ONE;
            if (n_phase_drop > PHASE_MAX) begin
                n_phase_drop = PHASE_MAX;
            end
        end
        o_status.phase_lt_one = (r_phase < PHASE_ONE);
        o_status.next_lt_one  = (n_phase_sum < PHASE_ONE);
    end

    assign diff_l = (SAMPLE_W + 1)'(r_cur_l) - (SAMPLE_W + 1)'(r_prev_l);
    assign diff_r = (SAMPLE_W + 1)'(r_cur_r) - (SAMPLE_W + 1)'(r_prev_r);
    assign frac   = $signed({1'b0, r_phase[FRAC_BITS-1:0]});

    // The interpolated value lies between prev and cur, so the sum wraps safely
    // in 24 bits.
    assign shift_l  = r_prod_l >>> FRAC_BITS;
    assign shift_r  = r_prod_r >>> FRAC_BITS;
    assign interp_l = r_prev_l + shift_l[SAMPLE_W-1:0];
    assign interp_r = r_prev_r + shift_r[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_phase  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            if (i_cmd.norm && !r_primed) begin
                r_primed <= 1'b1;
                r_prev_l <= n_norm_l;
                r_prev_r <= n_norm_r;
            end
            if (i_cmd.mul) begin
                r_phase <= n_phase_sum;
            end
            if (i_cmd.finish) begin
                r_phase  <= n_phase_drop;
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_left_raw  <= i_left_raw;
            r_right_raw <= i_right_raw;
            r_silent    <= i_silent;
        end
        if (i_cmd.norm) begin
            r_cur_l <= n_norm_l;
            r_cur_r <= n_norm_r;
        end
        if (i_cmd.mul) begin
            r_prod_l <= PROD_W'(diff_l) * PROD_W'(frac);
            r_prod_r <= PROD_W'(diff_r) * PROD_W'(frac);
        end
        if (i_cmd.scale) begin
            r_scl_l <= SCL_W'(interp_l) * SCL_W'(SCALE_K);
            r_scl_r <= SCL_W'(interp_r) * SCL_W'(SCALE_K);
        end
        if (i_cmd.load_out) begin
            r_left_out  <= to_s16(r_scl_l);
            r_right_out <= to_s16(r_scl_r);
            r_last      <= i_cmd.last;
        end
    end

    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
    assign o_last      = r_last;

    `SLR_ASSERT_NEXT(a_phase_saturated, i_cmd.finish, r_phase <= PHASE_MAX, "stored phase exceeds its range")
    `SLR_ASSERT_NOW(a_primed_before_mul, i_cmd.mul, r_primed, "interpolation started before priming")
    `SLR_ASSERT_NEXT(a_norm_primes, i_cmd.norm, r_primed, "normalisation left the history unprimed")

endmodule

[tb/sv/slr_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the stereo linear resampler: tracks the APB register writes, predicts the
// interpolated samples of every accepted frame and compares each output transfer in order.
// Depends on slr_pkg and the slr_in_if and slr_out_if channel interfaces.
module slr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    slr_in_if                          i_frame_ch,
    slr_out_if                         i_sample_ch,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [slr_pkg::ADDR_W-1:0] i_paddr,
    input  logic [slr_pkg::DATA_W-1:0] i_pwdata,
    input  logic                       i_pready,
    output int                         o_mismatches,
    output int                         o_pending
);
    import slr_pkg::*;

    localparam logic [63:0] PHASE_ONE = 64'(1) << FRAC_BITS_DEF;
    localparam logic [63:0] PHASE_MAX = (64'(1) << (FRAC_BITS_DEF + 4)) - 64'(1);
    localparam int          Q_POS_MAX = 8388607;
    localparam int          Q_NEG_MAX = -8388608;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    last;
    } t_stereo_sample;

    t_fmt              cfg_fmt;
    logic              cfg_mono;
    logic [STEP_W-1:0] cfg_step;

    logic [63:0]       acc_phase;
    int                hist_left;
    int                hist_right;
    logic              primed;

    t_stereo_sample    resampled_q[$];
    t_stereo_sample    want;
    int                mismatches = 0;

    // Raw sample bits to signed Q1.23.
    function automatic int norm_sample(input logic [31:0] raw, input t_fmt fmt);
        logic [7:0]  ex;
        logic [22:0] man;
        int          sh;
        int          mag;
        ex  = raw[30:23];
        man = raw[22:0];
        case (fmt)
            FMT_INT16: begin
                return int'($signed(raw[15:0])) * 256;
            end
            FMT_INT32: begin
                return int'($signed(raw[31:8]));
            end
            FMT_FLOAT32: begin
                if (ex == 8'hFF && man != 23'd0) return 0;
                if (ex >= 8'd127) return raw[31] ? Q_NEG_MAX : Q_POS_MAX;
                if (ex == 8'd0) return 0;
                sh = 127 - int'(ex);
                if (sh >= 24) return 0;
                mag = int'({1'b1, man} >> sh);
                return raw[31] ? -mag : mag;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    // Linear blend with the correction rounded towards minus infinity.
    function automatic int blend(input int a, input int b, input logic [63:0] frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac);
        return a + int'(prod >>> FRAC_BITS_DEF);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_pcm(input int v);
        longint p;
        longint mag;
        longint r;
        p   = longint'(v) * 32767;
        mag = (p < 0) ? -p : p;
        mag = mag >> 23;
        r   = (p < 0) ? -mag : mag;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return OUT_W'(r);
    endfunction

    task automatic resample_frame(input logic [31:0] l_raw, input logic [31:0] r_raw,
                                  input logic silent);
        int             cur_left;
        int             cur_right;
        int             n;
        t_stereo_sample s;
        cur_left  = 0;
        cur_right = 0;
        n         = 0;
        if (!silent) begin
            cur_left  = norm_sample(l_raw, cfg_fmt);
            cur_right = cfg_mono ? cur_left : norm_sample(r_raw, cfg_fmt);
        end
        if (!primed) begin
            hist_left  = cur_left;
            hist_right = cur_right;
            primed     = 1'b1;
        end
        while (acc_phase < PHASE_ONE && n < MAX_OUTPUTS_DEF) begin
            s.left  = to_pcm(blend(hist_left, cur_left, acc_phase));
            s.right = to_pcm(blend(hist_right, cur_right, acc_phase));
            s.last  = !((acc_phase + 64'(cfg_step)) < PHASE_ONE && n + 1 < MAX_OUTPUTS_DEF);
            resampled_q.push_back(s);
            n++;
            acc_phase = acc_phase + 64'(cfg_step);
        end
        // A loop cut short by the output cap restarts the phase from zero.
        if (acc_phase >= PHASE_ONE) acc_phase = acc_phase - PHASE_ONE;
        else acc_phase = 64'd0;
        if (acc_phase > PHASE_MAX) acc_phase = PHASE_MAX;
        hist_left  = cur_left;
        hist_right = cur_right;
    endtask

    function automatic void check_field(input string what, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_fmt    = FMT_INT16;
            cfg_mono   = 1'b0;
            cfg_step   = STEP_RESET;
            acc_phase  = 64'd0;
            hist_left  = 0;
            hist_right = 0;
            primed     = 1'b0;
            resampled_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_SAMPLE_FORMAT: cfg_fmt  = t_fmt'(i_pwdata[1:0]);
                    REG_MONO_INPUT:    cfg_mono = i_pwdata[0];
                    REG_STEP_RATIO:    cfg_step = i_pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample_ch.valid && i_sample_ch.ready) begin
                if (resampled_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output sample, expected none, actual %0d %0d %0b",
                             $time, i_sample_ch.left_out, i_sample_ch.right_out,
                             i_sample_ch.last);
                end else begin
                    want = resampled_q.pop_front();
                    check_field("left_out", want.left, i_sample_ch.left_out);
                    check_field("right_out", want.right, i_sample_ch.right_out);
                    check_field("last", {31'd0, want.last}, {31'd0, i_sample_ch.last});
                end
            end
            if (i_frame_ch.valid && i_frame_ch.ready) begin
                resample_frame(i_frame_ch.left_raw, i_frame_ch.right_raw, i_frame_ch.silent);
            end
        end
        o_pending    <= resampled_q.size();
        o_mismatches <= mismatches;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the resampler testbench: clock, reset, APB set-up, frame stimulus and output stalls.
// Depends on slr_pkg, the channel interfaces, stereo_linear_resampler and slr_checker.
module tb;
    import slr_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 3 * MAX_OUTPUTS_DEF + 8;
    localparam logic [1:0] REG_UNMAPPED   = 2'd3;

    typedef enum int {RX_FLOW, RX_HALF, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                pending;
    int                idle_cycles = 0;
    t_rx_mode          rx_mode     = RX_FLOW;
    int                rx_left     = 0;
    t_fmt              cur_fmt;

    slr_in_if  in_ch ();
    slr_out_if out_ch ();

    stereo_linear_resampler DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    slr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_ch   (in_ch),
        .i_sample_ch  (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The receiver switches between free flow, random stalls and long holds.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 48);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_FLOW:   out_ch.ready <= 1'b1;
            RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_frame(input logic [31:0] l_raw, input logic [31:0] r_raw,
                              input logic silent);
        in_ch.valid     <= 1'b1;
        in_ch.left_raw  <= l_raw;
        in_ch.right_raw <= r_raw;
        in_ch.silent    <= silent;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // A frame giving no output can still be in flight once the last sample is out.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access phases; the caller releases the bus after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic configure(input t_fmt fmt, input logic mono, input logic [STEP_W-1:0] step);
        settle();
        write_reg(REG_SAMPLE_FORMAT, {30'($urandom()), fmt});
        write_reg(REG_MONO_INPUT, {31'($urandom()), mono});
        write_reg(REG_STEP_RATIO, {12'($urandom()), step});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_fmt = fmt;
    endtask

    // Float frames mostly sit in the normal range around one so that the interpolation is busy.
    function automatic logic [31:0] rand_raw(input t_fmt fmt);
        if (fmt == FMT_FLOAT32 && $urandom_range(0, 3) != 0) begin
            return {1'($urandom()), 8'($urandom_range(100, 128)), 23'($urandom())};
        end
        return $urandom();
    endfunction

    task automatic run_stream(input int count);
        int sent;
        int burst;
        int gap;
        int bursts;
        sent   = 0;
        bursts = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_frame(rand_raw(cur_fmt), rand_raw(cur_fmt), $urandom_range(0, 7) == 0);
                sent++;
            end
            bursts++;
            if (sent < count) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (bursts == 2 || $urandom_range(0, 15) == 0) begin
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end else if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.left_raw  = '0;
        in_ch.right_raw = '0;
        in_ch.silent    = 1'b0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_rst_n         = 1'b0;
        cur_fmt         = FMT_INT16;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: int16 stereo at unity ratio; the first frame primes the history.
        send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
        send_frame(32'hFFFF_8000, 32'h1234_7FFF, 1'b0);
        send_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_frame(32'h0000_7FFF, 32'h0000_7FFF, 1'b1);
        send_frame(32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
        in_ch.valid <= 1'b0;

        configure(FMT_INT32, 1'b1, STEP_W'(8192));
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_frame(32'h0000_00FF, 32'hFFFF_FFFF, 1'b0);
        send_frame(32'hFFFF_FFFF, 32'h0000_0100, 1'b0);
        in_ch.valid <= 1'b0;

        // Saturation, infinities, NaN, subnormals and exponents just below the smallest that survives.
        configure(FMT_FLOAT32, 1'b0, STEP_W'(40000));
        send_frame(32'h3F80_0000, 32'hBF80_0000, 1'b0);
        send_frame(32'h7F80_0000, 32'hFF80_0000, 1'b0);
        send_frame(32'h7FC0_0000, 32'h0000_0001, 1'b0);
        send_frame(32'h3F00_0000, 32'hBF40_0000, 1'b0);
        send_frame(32'h3300_0000, 32'hB380_0000, 1'b0);
        send_frame(32'h3F7F_FFFF, 32'hBF7F_FFFF, 1'b0);
        send_frame(32'h4B00_0000, 32'h807F_FFFF, 1'b0);
        in_ch.valid <= 1'b0;

        configure(FMT_NONE, 1'b0, STEP_W'(65536));
        send_frame($urandom(), $urandom(), 1'b0);
        send_frame($urandom(), $urandom(), 1'b0);
        in_ch.valid <= 1'b0;

        // A write to the unused word must leave every register alone.
        settle();
        write_reg(REG_UNMAPPED, $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;

        // A ratio this small hits the output cap on every frame.
        configure(FMT_INT16, 1'b0, STEP_W'(5000));
        send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
        send_frame(32'h0000_8000, 32'h0000_7FFF, 1'b0);
        send_frame(32'h0000_1234, 32'h0000_EDCB, 1'b0);
        in_ch.valid <= 1'b0;

        configure(FMT_INT16, 1'b0, STEP_W'(65536));
        run_stream(40);
        configure(FMT_INT32, 1'b1, STEP_W'(8192));
        run_stream(40);
        configure(FMT_FLOAT32, 1'b0, STEP_W'(524288));
        run_stream(50);
        configure(FMT_FLOAT32, 1'b1, STEP_W'($urandom_range(8192, 524288)));
        run_stream(40);
        configure(FMT_INT16, 1'b1, STEP_W'(524288));
        run_stream(40);
        configure(FMT_NONE, 1'b0, STEP_W'($urandom_range(8192, 524288)));
        run_stream(20);
        configure(FMT_INT32, 1'b0, STEP_W'($urandom_range(8192, 524288)));
        run_stream(40);
        configure(FMT_INT16, 1'b0, STEP_W'($urandom_range(0, 8191)));
        run_stream(30);
        configure(FMT_FLOAT32, 1'b0, STEP_W'($urandom_range(8192, 131072)));
        run_stream(50);
        configure(FMT_INT16, 1'b0, STEP_W'($urandom_range(8192, 524288)));
        run_stream(60);

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[stereo_linear_resampler.f]
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_in_if.sv
rtl/slr_out_if.sv
rtl/slr_ctrl.sv
rtl/slr_datapath.sv
rtl/stereo_linear_resampler.sv
tb/sv/slr_checker.sv
tb/sv/tb.sv
